### hdl/two_level_page_walk_macros.svh
// Assertion macros shared by the checker of the two-level page walker.
`ifndef TWO_LEVEL_PAGE_WALK_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_MACROS_SVH

// Checks that post holds in the same cycle whenever pre holds.
`define TLPW_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Checks that post holds in the cycle after pre holds.
`define TLPW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/tlpw_pkg.sv
// Types, codes and entry helpers of the two-level page walker.
`default_nettype none

package tlpw_pkg;

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_UPDATE    = 2'd1;
  localparam logic [1:0] ACT_WR_DIR    = 2'd2;
  localparam logic [1:0] ACT_WR_TABLE  = 2'd3;

  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned DIR_WIDTH   = 5;
  localparam int unsigned DIR_AW      = 10;
  localparam int unsigned ENTRY_WIDTH = 32;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] vaddr;
    logic [3:0]  flags;
    logic [3:0]  table_slot;
    logic        dir_present;
    logic [31:0] entry_word;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] page_address;
    logic [31:0] paddr;
    logic [3:0]  flags_out;
  } rsp_t;

  function automatic logic slot_ok(logic [3:0] slot, int unsigned slots);
    return 32'(slot) < slots;
  endfunction

  // Flags of a present entry: read and execute always, write and user from the entry.
  function automatic logic [3:0] to_abstract(logic [31:0] entry);
    return {entry[2], 1'b1, entry[1], 1'b1};
  endfunction

  // Entry with its frame kept and present, writable and user taken from the flags.
  function automatic logic [31:0] to_entry(logic [31:0] entry, logic [3:0] fl);
    return {entry[31:12], 9'd0, fl[3], fl[1], fl[0]};
  endfunction

endpackage

`default_nettype wire

### hdl/tlpw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module tlpw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/two_level_page_walk.sv
// Two-level page walker: a sequencer over a directory RAM and a page table RAM.
// After reset the block clears both memories, one entry of each per cycle, until
// every table entry is clear, and holds request_stall high during that pass. It then
// takes one request at a time. A translate or an update reads the directory in the
// cycle of acceptance and, when that entry is present with a valid slot, the table
// entry in the next; it loads its result into the output register once the register
// is free. Directory and table writes are made as their result is loaded. The table
// read depends on the registered directory read; a stalled result delays the
// write-back and the next acceptance until the output register frees. Request_stall
// is low again in the cycle after a result is loaded.
`default_nettype none

module two_level_page_walk
  import tlpw_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic request_valid,
  output logic      request_stall,
  input  wire req_t request,
  output logic      result_valid,
  input  wire logic result_stall,
  output rsp_t      result
);

  localparam int unsigned TBL_DEPTH = TABLE_SLOTS * DIR_ENTRIES;
  localparam int unsigned TW        = $clog2(TBL_DEPTH);
  localparam logic [TW-1:0] CLR_LAST = TW'(TBL_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIR   = 3'd2;
  localparam logic [2:0] ST_TBL   = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;

  logic [2:0]    state, state_next;
  logic [TW-1:0] clr_addr, clr_addr_next;
  logic [TW-1:0] tbl_addr, tbl_addr_next;
  req_t          req_q;
  rsp_t          rsp_next;
  logic          accept, out_free, load;

  logic                   dir_we, dir_re;
  logic [DIR_AW-1:0]      dir_waddr, dir_raddr;
  logic [DIR_WIDTH-1:0]   dir_wdata, dir_rdata;
  logic                   tbl_we, tbl_re;
  logic [TW-1:0]          tbl_waddr, tbl_raddr;
  logic [ENTRY_WIDTH-1:0] tbl_wdata, tbl_rdata;

  assign accept   = request_valid && !request_stall;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    tbl_addr_next = tbl_addr;
    request_stall = (state != ST_IDLE);
    load          = 1'b0;
    dir_we        = 1'b0;
    dir_waddr     = clr_addr[DIR_AW-1:0];
    dir_wdata     = '0;
    dir_re        = 1'b0;
    dir_raddr     = request.vaddr[31:22];
    tbl_we        = 1'b0;
    tbl_waddr     = clr_addr;
    tbl_wdata     = '0;
    tbl_re        = 1'b0;
    tbl_raddr     = TW'({dir_rdata[3:0], req_q.vaddr[21:12]});
    rsp_next.ok           = 1'b0;
    rsp_next.page_address = {req_q.vaddr[31:12], 12'd0};
    rsp_next.paddr        = '0;
    rsp_next.flags_out    = '0;
    unique case (state)
      ST_CLEAR: begin
        dir_we        = 1'b1;
        tbl_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (request_valid) begin
          if (request.action == ACT_TRANSLATE || request.action == ACT_UPDATE) begin
            dir_re     = 1'b1;
            state_next = ST_DIR;
          end else begin
            state_next = ST_WR;
          end
        end
      end
      ST_DIR: begin
        if (dir_rdata[4] && slot_ok(dir_rdata[3:0], TABLE_SLOTS)) begin
          tbl_re        = 1'b1;
          tbl_addr_next = tbl_raddr;
          state_next    = ST_TBL;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TBL: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (req_q.action == ACT_TRANSLATE) begin
            if (tbl_rdata[0]) begin
              rsp_next.ok        = 1'b1;
              rsp_next.paddr     = {tbl_rdata[31:12], req_q.vaddr[11:0]};
              rsp_next.flags_out = to_abstract(tbl_rdata);
            end
          end else if (tbl_rdata[0] && req_q.flags[0]) begin
            rsp_next.ok = 1'b1;
            tbl_we      = 1'b1;
            tbl_waddr   = tbl_addr;
            tbl_wdata   = to_entry(tbl_rdata, req_q.flags);
          end
        end
      end
      ST_WR: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (slot_ok(req_q.table_slot, TABLE_SLOTS)) begin
            rsp_next.ok = 1'b1;
            if (req_q.action == ACT_WR_DIR) begin
              dir_we    = 1'b1;
              dir_waddr = req_q.vaddr[31:22];
              dir_wdata = {req_q.dir_present, req_q.table_slot};
            end else begin
              tbl_we    = 1'b1;
              tbl_waddr = TW'({req_q.table_slot, req_q.vaddr[21:12]});
              tbl_wdata = req_q.entry_word;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tbl_addr <= tbl_addr_next;
    if (accept) begin
      req_q <= request;
    end
    if (load) begin
      result <= rsp_next;
    end
  end

  tlpw_ram #(
    .WIDTH(DIR_WIDTH),
    .DEPTH(DIR_ENTRIES)
  ) u_dir_ram (
    .clk    (clk),
    .wr_en  (dir_we),
    .wr_addr(dir_waddr),
    .wr_data(dir_wdata),
    .rd_en  (dir_re),
    .rd_addr(dir_raddr),
    .rd_data(dir_rdata)
  );

  tlpw_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk    (clk),
    .wr_en  (tbl_we),
    .wr_addr(tbl_waddr),
    .wr_data(tbl_wdata),
    .rd_en  (tbl_re),
    .rd_addr(tbl_raddr),
    .rd_data(tbl_rdata)
  );

endmodule

`default_nettype wire

### hdl/tlpw_checker.sv
// Port-level assertions of the two-level page walker and their bind.
`default_nettype none

`include "two_level_page_walk_macros.svh"

module tlpw_checker
  import tlpw_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic request_valid,
  input wire logic request_stall,
  input wire logic result_valid,
  input wire logic result_stall,
  input wire rsp_t result
);

  `TLPW_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall,
                    result_valid && $stable(result), "stalled result changed")
  `TLPW_ASSERT_NEXT(a_one_at_a_time, clk, rst, request_valid && !request_stall,
                    request_stall, "request taken while another is at work")
  `TLPW_ASSERT_SAME(a_fault_zero, clk, rst, result_valid && !result.ok,
                    result.paddr == 32'd0 && result.flags_out == 4'd0,
                    "failed result carries a mapping")
  `TLPW_ASSERT_SAME(a_flags_read_exec, clk, rst, result_valid && result.flags_out != 4'd0,
                    result.flags_out[0] && result.flags_out[2], "mapping lacks read or execute")
  `TLPW_ASSERT_SAME(a_page_aligned, clk, rst, result_valid,
                    result.page_address[11:0] == 12'd0, "page address not aligned")

endmodule

bind two_level_page_walk tlpw_checker u_tlpw_checker (
  .clk          (clk),
  .rst          (rst),
  .request_valid(request_valid),
  .request_stall(request_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### tb/tb_two_level_page_walk.sv
// Self-checking testbench of the two-level page walker: directed table, random walks, predictor.
`timescale 1ns / 1ps

module tb_two_level_page_walk;
  import tlpw_pkg::*;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned TOTAL_REQUESTS = 1850;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;
  localparam logic [31:0] PTE_PRESENT = 32'h001;
  localparam logic [31:0] PTE_WRITABLE = 32'h002;
  localparam logic [31:0] PTE_USER = 32'h004;
  localparam logic [3:0] FL_READ = 4'h1;
  localparam logic [3:0] FL_WRITE = 4'h2;
  localparam logic [3:0] FL_EXEC = 4'h4;
  localparam logic [3:0] FL_USER = 4'h8;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } walk_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  req_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rsp_t result;

  bit [4:0] dir_copy [DIR_ENTRIES];
  bit [31:0] pte_copy [TABLE_SLOTS * DIR_ENTRIES];
  rsp_t walk_results_due [$];
  req_t planned_requests [$];
  walk_row_t directed_rows [$];
  logic [9:0] dir_pool [8];
  logic [9:0] tab_pool [8];
  logic [3:0] slot_pool [4];
  int unsigned requests_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit gapless = 1'b0;
  rsp_t due;

  two_level_page_walk #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_two_level_page_walk: FAIL");
      $finish;
    end
  end

  function automatic rsp_t walk_result(req_t r);
    rsp_t o;
    logic [9:0] di;
    logic [9:0] ti;
    logic [4:0] de;
    logic [31:0] e;
    int unsigned pos;
    bit hit;
    di = r.vaddr[31:22];
    ti = r.vaddr[21:12];
    de = dir_copy[di];
    pos = 32'({de[3:0], ti});
    e = pte_copy[pos];
    hit = de[4] && (32'(de[3:0]) < TABLE_SLOTS) && ((e & PTE_PRESENT) != 0);
    o = '0;
    o.page_address = r.vaddr & PAGE_MASK;
    case (r.action)
      ACT_TRANSLATE: begin
        if (hit) begin
          o.ok = 1'b1;
          o.paddr = (e & PAGE_MASK) | (r.vaddr & ~PAGE_MASK);
          o.flags_out = FL_READ | FL_EXEC;
          if ((e & PTE_WRITABLE) != 0) o.flags_out = o.flags_out | FL_WRITE;
          if ((e & PTE_USER) != 0) o.flags_out = o.flags_out | FL_USER;
        end
      end
      ACT_UPDATE: begin
        if (((r.flags & FL_READ) != 0) && hit) begin
          e = (e & PAGE_MASK) | PTE_PRESENT;
          if ((r.flags & FL_WRITE) != 0) e = e | PTE_WRITABLE;
          if ((r.flags & FL_USER) != 0) e = e | PTE_USER;
          pte_copy[pos] = e;
          o.ok = 1'b1;
        end
      end
      ACT_WR_DIR: begin
        if (32'(r.table_slot) < TABLE_SLOTS) begin
          dir_copy[di] = {r.dir_present, r.table_slot};
          o.ok = 1'b1;
        end
      end
      ACT_WR_TABLE: begin
        if (32'(r.table_slot) < TABLE_SLOTS) begin
          pte_copy[{r.table_slot, ti}] = r.entry_word;
          o.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t req_of(logic [1:0] action, logic [31:0] va, logic [3:0] flags,
                                  logic [3:0] slot, logic dp, logic [31:0] word);
    req_t r;
    r.action = action;
    r.vaddr = va;
    r.flags = flags;
    r.table_slot = slot;
    r.dir_present = dp;
    r.entry_word = word;
    return r;
  endfunction

  function automatic rsp_t rsp_of(logic ok, logic [31:0] page, logic [31:0] phys,
                                  logic [3:0] fl);
    rsp_t o;
    o.ok = ok;
    o.page_address = page;
    o.paddr = phys;
    o.flags_out = fl;
    return o;
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.action = 2'($urandom_range(0, 3));
    r.vaddr = $urandom;
    r.flags = 4'($urandom_range(0, 15));
    r.table_slot = 4'($urandom_range(0, 15));
    r.dir_present = 1'($urandom_range(0, 1));
    r.entry_word = $urandom;
    return r;
  endfunction

  task automatic plan_traffic();
    req_t r;
    logic [9:0] di;
    logic [9:0] ti;
    logic [3:0] slot;
    if ($urandom_range(0, 99) < 60) begin
      di = dir_pool[$urandom_range(0, 7)];
      ti = tab_pool[$urandom_range(0, 7)];
      slot = slot_pool[$urandom_range(0, 3)];
      r = random_fields();
      r.action = ACT_WR_DIR;
      r.vaddr[31:22] = di;
      r.table_slot = slot;
      r.dir_present = ($urandom_range(0, 9) != 0);
      planned_requests.push_back(r);
      r = random_fields();
      r.action = ACT_WR_TABLE;
      r.vaddr[21:12] = ti;
      r.table_slot = slot;
      r.entry_word[0] = ($urandom_range(0, 9) != 0);
      planned_requests.push_back(r);
      repeat ($urandom_range(1, 4)) begin
        r = random_fields();
        r.action = ($urandom_range(0, 99) < 60) ? ACT_TRANSLATE : ACT_UPDATE;
        r.vaddr[31:22] = di;
        r.vaddr[21:12] = ti;
        r.flags[0] = ($urandom_range(0, 99) < 85);
        planned_requests.push_back(r);
      end
    end else begin
      r = random_fields();
      if ($urandom_range(0, 99) < 70) begin
        r.vaddr[31:22] = dir_pool[$urandom_range(0, 7)];
        r.vaddr[21:12] = tab_pool[$urandom_range(0, 7)];
        r.table_slot = slot_pool[$urandom_range(0, 3)];
      end
      planned_requests.push_back(r);
    end
  endtask

  task automatic offer(input req_t r, input logic typed, input rsp_t want);
    rsp_t predicted;
    request <= r;
    request_valid <= 1'b1;
    do @(posedge clk); while (request_stall);
    predicted = walk_result(r);
    walk_results_due.push_back(typed ? want : predicted);
    requests_taken++;
    gapless = (requests_taken >= 900 && requests_taken < 1300);
    if (!gapless && $urandom_range(0, 99) < 14) begin
      request_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (walk_results_due.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, result);
        mismatches++;
      end else begin
        due = walk_results_due.pop_front();
        compare_field("ok", 32'(due.ok), 32'(result.ok));
        compare_field("page_address", due.page_address, result.page_address);
        compare_field("paddr", due.paddr, result.paddr);
        compare_field("flags_out", 32'(due.flags_out), 32'(result.flags_out));
      end
    end
  end

  initial begin : result_side
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && requests_taken >= 400) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= !gapless && ($urandom_range(0, 99) < 14);
    end
  end

  initial begin : request_side
    int i;
    dir_pool[0] = 10'h3FF;
    dir_pool[1] = 10'h000;
    tab_pool[0] = 10'h3FF;
    tab_pool[1] = 10'h000;
    for (i = 2; i < 8; i++) begin
      dir_pool[i] = 10'($urandom);
      tab_pool[i] = 10'($urandom);
    end
    slot_pool[0] = 4'hF;
    slot_pool[1] = 4'h0;
    slot_pool[2] = 4'($urandom);
    slot_pool[3] = 4'($urandom);

    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h0000_0000, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1, 32'hFFFF_FFFF),
                              1'b1, rsp_of(1'b0, 32'hFFFF_F000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'hFFFF_FFFF, 4'hF, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'hFFFF_F000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_DIR, 32'hFFC0_0000, 4'h0, 4'hF, 1'b1, 32'h0),
                              1'b1, rsp_of(1'b1, 32'hFFC0_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'hFFFF_F000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_TABLE, 32'hFFFF_F000, 4'h0, 4'hF, 1'b0, 32'hFFFF_FFFF),
                              1'b1, rsp_of(1'b1, 32'hFFFF_F000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b1, 32'hFFFF_F000, 32'hFFFF_FFFF, 4'hF)});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'hFFFF_F123, 4'hE, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'hFFFF_F000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'hFFFF_FABC, 4'h1, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'hFFFF_F000, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'hFFFF_F000, 4'hF, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});
    directed_rows.push_back('{req_of(ACT_WR_DIR, 32'h0000_0000, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b1, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_TABLE, 32'h0000_0000, 4'h0, 4'h0, 1'b0, 32'h1),
                              1'b1, rsp_of(1'b1, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h0000_0FFF, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_DIR, 32'h0000_0000, 4'h0, 4'h0, 1'b1, 32'h0),
                              1'b1, rsp_of(1'b1, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h0000_0FFF, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});
    directed_rows.push_back('{req_of(ACT_WR_TABLE, 32'h0000_0000, 4'h0, 4'h0, 1'b0, 32'hFFFF_F000),
                              1'b1, rsp_of(1'b1, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h0000_0ABC, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'h0000_0000, 4'hF, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h0000_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_DIR, 32'h5540_0000, 4'hF, 4'h5, 1'b1, 32'hFFFF_FFFF),
                              1'b1, rsp_of(1'b1, 32'h5540_0000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_TABLE, 32'h556A_A000, 4'h0, 4'h5, 1'b0, 32'hAAAA_A006),
                              1'b1, rsp_of(1'b1, 32'h556A_A000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h556A_A555, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h556A_A000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'h556A_A000, 4'h9, 4'h0, 1'b0, 32'h0),
                              1'b1, rsp_of(1'b0, 32'h556A_A000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_WR_TABLE, 32'h556A_A000, 4'h0, 4'h5, 1'b0, 32'h5555_5003),
                              1'b1, rsp_of(1'b1, 32'h556A_A000, 32'h0, 4'h0)});
    directed_rows.push_back('{req_of(ACT_TRANSLATE, 32'h556A_A555, 4'h0, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});
    directed_rows.push_back('{req_of(ACT_UPDATE, 32'h556A_A555, 4'h9, 4'h0, 1'b0, 32'h0),
                              1'b0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++)
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    while (requests_taken < TOTAL_REQUESTS) begin
      if (planned_requests.size() == 0) plan_traffic();
      offer(planned_requests.pop_front(), 1'b0, '0);
    end
    request_valid <= 1'b0;

    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_two_level_page_walk: PASS");
    end else begin
      $display("tb_two_level_page_walk: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/tlpw_pkg.sv
hdl/tlpw_ram.sv
hdl/two_level_page_walk.sv
hdl/tlpw_checker.sv
tb/tb_two_level_page_walk.sv
